// ===== rtl/tcaof_pkg.sv =====
// Shared types and constants for the two-class age-ordered FIFO.
package tcaof_pkg;

    localparam int TAG_PORT_W = 16;

    typedef enum logic [1:0] {
        OP_ENQ     = 2'd0,
        OP_DEQ_ANY = 2'd1,
        OP_DEQ_DOG = 2'd2,
        OP_DEQ_CAT = 2'd3
    } op_t;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic capture;
        logic execute;
    } dp_cmd_t;

    typedef struct packed {
        logic res_free;
    } dp_sts_t;

endpackage

// ===== rtl/tcaof_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tcaof_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tcaof_ctrl.sv =====
// Controller state machine: request capture and execute sequencing.
module tcaof_ctrl
    import tcaof_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_stall,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        req_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.res_free)
                begin
                    cmd.execute = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/tcaof_dp.sv =====
// Datapath: class stores, pointers, counts, arrival stamp and result register.
module tcaof_dp
    import tcaof_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16,
    parameter int STAMP_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts,
    input  logic [1:0]            operation,
    input  logic                  item_class,
    input  logic [TAG_PORT_W-1:0] item_tag,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic [1:0]            status,
    output logic                  out_valid,
    output logic [TAG_PORT_W-1:0] out_tag,
    output logic                  out_class
);

    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_W = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
    localparam int EW    = TAG_W + STAMP_BITS;
    localparam logic [CW-1:0] COUNT_FULL = CW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] PTR_LAST   = PW'(QUEUE_DEPTH - 1);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PTR_LAST)
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    // captured transaction
    op_t                op_reg;
    logic               class_reg;
    logic [TAG_W-1:0]   tag_reg;

    logic [PW-1:0]      dog_head_reg, dog_tail_reg, cat_head_reg, cat_tail_reg;
    logic [CW-1:0]      dog_count_reg, cat_count_reg;
    logic [STAMP_BITS-1:0] arrival_reg;

    logic               res_valid_reg;
    logic [1:0]         status_reg;
    logic               out_valid_reg;
    logic [TAG_PORT_W-1:0] out_tag_reg;
    logic               out_class_reg;

    logic [EW-1:0]      dog_rd, cat_rd, wr_entry;
    logic               dog_wr, cat_wr, dog_pop, cat_pop;
    logic               dog_empty, cat_empty, cat_older, pick, deq;
    logic [STAMP_BITS-1:0] stamp_diff;
    logic [1:0]         res_status;
    logic               res_item_valid, res_class;
    logic [TAG_PORT_W-1:0] res_tag;

    assign wr_entry = {tag_reg, arrival_reg};

    tcaof_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_dog_ram (
        .clk     (clk),
        .wr_en   (cmd.execute & dog_wr),
        .wr_addr (dog_tail_reg),
        .wr_data (wr_entry),
        .rd_addr (dog_head_reg),
        .rd_data (dog_rd)
    );

    tcaof_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_cat_ram (
        .clk     (clk),
        .wr_en   (cmd.execute & cat_wr),
        .wr_addr (cat_tail_reg),
        .wr_data (wr_entry),
        .rd_addr (cat_head_reg),
        .rd_data (cat_rd)
    );

    assign dog_empty  = (dog_count_reg == '0);
    assign cat_empty  = (cat_count_reg == '0);
    assign stamp_diff = cat_rd[STAMP_BITS-1:0] - dog_rd[STAMP_BITS-1:0];
    assign cat_older  = stamp_diff[STAMP_BITS-1];

    always_comb
    begin
        dog_wr         = 1'b0;
        cat_wr         = 1'b0;
        dog_pop        = 1'b0;
        cat_pop        = 1'b0;
        deq            = 1'b0;
        pick           = 1'b0;
        res_status     = STATUS_OK;
        res_item_valid = 1'b0;
        res_class      = 1'b0;
        res_tag        = '0;
        case (op_reg)
            OP_ENQ:
            begin
                if (class_reg ? (cat_count_reg == COUNT_FULL)
                              : (dog_count_reg == COUNT_FULL))
                begin
                    res_status = STATUS_FULL;
                end
                else
                begin
                    cat_wr = class_reg;
                    dog_wr = !class_reg;
                end
            end
            OP_DEQ_ANY:
            begin
                deq  = 1'b1;
                pick = dog_empty ? 1'b1 : (cat_empty ? 1'b0 : cat_older);
            end
            OP_DEQ_DOG:
            begin
                deq  = 1'b1;
                pick = 1'b0;
            end
            OP_DEQ_CAT:
            begin
                deq  = 1'b1;
                pick = 1'b1;
            end
            default:
            begin
                deq = 1'b0;
            end
        endcase
        if (deq)
        begin
            if (pick ? cat_empty : dog_empty)
            begin
                res_status = STATUS_EMPTY;
            end
            else
            begin
                cat_pop        = pick;
                dog_pop        = !pick;
                res_item_valid = 1'b1;
                res_class      = pick;
                res_tag[TAG_W-1:0] = pick ? cat_rd[EW-1:STAMP_BITS]
                                          : dog_rd[EW-1:STAMP_BITS];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op_t'(operation);
            class_reg <= item_class;
            tag_reg   <= item_tag[TAG_W-1:0];
        end
        if (cmd.execute)
        begin
            status_reg    <= res_status;
            out_valid_reg <= res_item_valid;
            out_tag_reg   <= res_tag;
            out_class_reg <= res_class;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dog_head_reg  <= '0;
            dog_tail_reg  <= '0;
            dog_count_reg <= '0;
            cat_head_reg  <= '0;
            cat_tail_reg  <= '0;
            cat_count_reg <= '0;
            arrival_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.execute)
            begin
                res_valid_reg <= 1'b1;
                if (dog_wr)
                begin
                    dog_tail_reg  <= ptr_inc(dog_tail_reg);
                    dog_count_reg <= dog_count_reg + CW'(1);
                    arrival_reg   <= arrival_reg + STAMP_BITS'(1);
                end
                if (cat_wr)
                begin
                    cat_tail_reg  <= ptr_inc(cat_tail_reg);
                    cat_count_reg <= cat_count_reg + CW'(1);
                    arrival_reg   <= arrival_reg + STAMP_BITS'(1);
                end
                if (dog_pop)
                begin
                    dog_head_reg  <= ptr_inc(dog_head_reg);
                    dog_count_reg <= dog_count_reg - CW'(1);
                end
                if (cat_pop)
                begin
                    cat_head_reg  <= ptr_inc(cat_head_reg);
                    cat_count_reg <= cat_count_reg - CW'(1);
                end
            end
            else if (!rsp_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.res_free = !res_valid_reg || !rsp_stall;
    assign rsp_valid    = res_valid_reg;
    assign status       = status_reg;
    assign out_valid    = out_valid_reg;
    assign out_tag      = out_tag_reg;
    assign out_class    = out_class_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dog_count_reg <= COUNT_FULL) && (cat_count_reg <= COUNT_FULL))
        else $error("queue occupancy beyond depth");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |-> (!res_valid_reg || !rsp_stall))
        else $error("result register overwritten while stalled");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> res_valid_reg)
        else $error("executed transaction produced no result");

    a_counts_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.execute |=> ($stable(dog_count_reg) && $stable(cat_count_reg)
                          && $stable(arrival_reg)))
        else $error("queue state changed without execute");

endmodule

// ===== rtl/two_class_age_ordered_fifo_core.sv =====
// Two-class age-ordered FIFO: top level joining controller and datapath.
// A transaction is captured into the request registers, then executed once the result register is free.
// The controller takes no new request while a captured transaction waits in its execute state.
// The next request is taken while a result still waits on a stalled output.
// Reset (rst_n, async, active low) clears pointers, counts and the arrival stamp.
// The stores are not cleared; no clearing pass is needed.
module two_class_age_ordered_fifo_core
    import tcaof_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16,
    parameter int STAMP_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [1:0]            operation,
    input  logic                  item_class,
    input  logic [TAG_PORT_W-1:0] item_tag,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic [1:0]            status,
    output logic                  out_valid,
    output logic [TAG_PORT_W-1:0] out_tag,
    output logic                  out_class
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    tcaof_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    tcaof_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS),
        .STAMP_BITS  (STAMP_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .operation  (operation),
        .item_class (item_class),
        .item_tag   (item_tag),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .out_valid  (out_valid),
        .out_tag    (out_tag),
        .out_class  (out_class)
    );

endmodule

// ===== bench/two_class_age_ordered_fifo_core_tb.sv =====
// Self-checking testbench for the two-class age-ordered FIFO core.
module two_class_age_ordered_fifo_core_tb;
    import tcaof_pkg::*;

    localparam int DEPTH        = 16;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 2000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [1:0]            status;
        logic                  valid;
        logic [TAG_PORT_W-1:0] tag;
        logic                  cls;
    } result_t;

    class two_queue_tracker;
        bit [TAG_PORT_W-1:0] tags[2][DEPTH];
        bit [15:0]           stamps[2][DEPTH];
        int unsigned         head[2];
        int unsigned         count[2];
        bit [15:0]           arrival;
        result_t             pending_results[$];
        int mismatches, checked, stored, refused, empty_hits, taken;

        function result_t take_head(bit c);
            result_t r;
            r = result_t'{STATUS_EMPTY, 1'b0, '0, 1'b0};
            if (count[c] != 0)
            begin
                r = result_t'{STATUS_OK, 1'b1, tags[c][head[c]], c};
                head[c] = (head[c] + 1) % DEPTH;
                count[c]--;
                taken++;
            end
            else
            begin
                empty_hits++;
            end
            return r;
        endfunction

        function void note_request(op_t op, bit c, bit [TAG_PORT_W-1:0] tag);
            result_t     r;
            bit [15:0]   diff;
            int unsigned tail;
            r = result_t'{STATUS_OK, 1'b0, '0, 1'b0};
            case (op)
                OP_ENQ:
                begin
                    if (count[c] >= DEPTH)
                    begin
                        r.status = STATUS_FULL;
                        refused++;
                    end
                    else
                    begin
                        tail = (head[c] + count[c]) % DEPTH;
                        tags[c][tail] = tag;
                        stamps[c][tail] = arrival;
                        count[c]++;
                        arrival++;
                        stored++;
                    end
                end
                OP_DEQ_ANY:
                begin
                    if (count[0] == 0 && count[1] == 0)
                    begin
                        r.status = STATUS_EMPTY;
                        empty_hits++;
                    end
                    else if (count[0] == 0)
                    begin
                        r = take_head(1'b1);
                    end
                    else if (count[1] == 0)
                    begin
                        r = take_head(1'b0);
                    end
                    else
                    begin
                        // modular age compare: top bit set means the cat head is older
                        diff = stamps[1][head[1]] - stamps[0][head[0]];
                        r = take_head(diff[15]);
                    end
                end
                OP_DEQ_DOG:
                begin
                    r = take_head(1'b0);
                end
                default:
                begin
                    r = take_head(1'b1);
                end
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"ERROR: result with no transaction outstanding: ",
                              "status=%0d valid=%0d tag=%h class=%0d"},
                             got.status, got.valid, got.tag, got.cls);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.valid !== want.valid ||
                got.tag !== want.tag || got.cls !== want.cls)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"ERROR: result %0d: expected status=%0d valid=%0d tag=%h ",
                              "class=%0d, got status=%0d valid=%0d tag=%h class=%0d"},
                             checked, want.status, want.valid, want.tag, want.cls,
                             got.status, got.valid, got.tag, got.cls);
            end
        endfunction

        function void close_out();
            if (pending_results.size() != 0)
            begin
                $display("ERROR: %0d results never arrived", pending_results.size());
                mismatches += pending_results.size();
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    logic [1:0]            operation;
    logic                  item_class;
    logic [TAG_PORT_W-1:0] item_tag;
    logic                  rsp_valid;
    logic                  rsp_stall;
    logic [1:0]            status;
    logic                  out_valid;
    logic [TAG_PORT_W-1:0] out_tag;
    logic                  out_class;

    two_queue_tracker tracker = new();
    bit paced;
    bit hold_off_req;
    int burst_left;
    int stalled_offers;

    two_class_age_ordered_fifo_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .operation  (operation),
        .item_class (item_class),
        .item_tag   (item_tag),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .out_valid  (out_valid),
        .out_tag    (out_tag),
        .out_class  (out_class)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("Timeout: %0d results still outstanding", tracker.pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            tracker.check_result(result_t'{status, out_valid, out_tag, out_class});
    end

    // receiver back-pressure: changing modes, plus one long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        int streak;
        int phase;
        mode = 0;
        mode_left = 0;
        streak = 0;
        phase = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                rsp_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                rsp_stall = 1'b0;
                hold_off_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                phase++;
                if (streak > 0)
                    streak--;
                else if (mode == 1 && $urandom_range(0, 9) == 0)
                    streak = $urandom_range(1, 2);
                else if (mode == 2 && $urandom_range(0, 1) == 0)
                    streak = $urandom_range(1, 6);
                rsp_stall = (streak > 0) || (mode == 3 && phase % 3 != 0);
            end
        end
    end

    task automatic pace_sender();
        int idle;
        if (burst_left == 0)
        begin
            idle = $urandom_range(0, 8);
            if (idle > 0)
            begin
                req_valid = 1'b0;
                repeat (idle) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    task automatic send_request(op_t op, bit c, bit [TAG_PORT_W-1:0] tag);
        if (paced)
            pace_sender();
        req_valid = 1'b1;
        operation = op;
        item_class = c;
        item_tag = tag;
        @(posedge clk);
        while (req_stall)
        begin
            stalled_offers++;
            @(posedge clk);
        end
        tracker.note_request(op, c, tag);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        req_valid = 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic op_t pick_op(int bias);
        int threshold;
        case (bias)
            0:       threshold = 70;
            1:       threshold = 25;
            default: threshold = 50;
        endcase
        if ($urandom_range(0, 99) < threshold)
            return OP_ENQ;
        return op_t'($urandom_range(1, 3));
    endfunction

    initial
    begin
        int  i;
        int  sent;
        int  bias;
        int  run;
        bit  favoured;
        bit  c;

        rst_n = 1'b0;
        req_valid = 1'b0;
        operation = OP_ENQ;
        item_class = 1'b0;
        item_tag = '0;
        paced = 1'b0;
        hold_off_req = 1'b0;
        burst_left = 0;
        stalled_offers = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty queues, a full dog queue, age ordering between classes
        send_request(OP_DEQ_ANY, 1'b1, 16'hFFFF);
        send_request(OP_DEQ_DOG, 1'b1, 16'h0000);
        send_request(OP_DEQ_CAT, 1'b0, 16'hFFFF);
        send_request(OP_ENQ, 1'b1, 16'hFFFF);
        for (i = 0; i < DEPTH; i++)
            send_request(OP_ENQ, 1'b0, 16'(i * 'h1111));
        send_request(OP_ENQ, 1'b0, 16'h1234);
        send_request(OP_ENQ, 1'b1, 16'h5A5A);
        send_request(OP_DEQ_ANY, 1'b0, 16'h0000);
        send_request(OP_DEQ_ANY, 1'b1, 16'hFFFF);
        send_request(OP_DEQ_CAT, 1'b0, 16'h0000);
        send_request(OP_DEQ_ANY, 1'b0, 16'hA5A5);
        send_request(OP_DEQ_DOG, 1'b1, 16'h0000);
        wait_drain();

        // long output hold-off with the sender still offering
        hold_off_req = 1'b1;
        for (i = 0; i < 48; i++)
            send_request(pick_op(2), 1'($urandom), 16'($urandom));
        wait_drain();

        // random runs biased towards filling or draining one class
        paced = 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            bias = $urandom_range(0, 2);
            run = $urandom_range(8, 60);
            favoured = 1'($urandom);
            repeat (run)
            begin
                c = ($urandom_range(0, 3) == 0) ? ~favoured : favoured;
                send_request(pick_op(bias), c, 16'($urandom));
                sent++;
            end
        end
        wait_drain();
        repeat (8) @(posedge clk);

        tracker.close_out();
        $display("Checked %0d transactions: %0d stored, %0d refused full, %0d empty, %0d returned",
                 tracker.checked, tracker.stored, tracker.refused, tracker.empty_hits,
                 tracker.taken);
        $display("Full and empty queues, a long output hold-off; input stalled on %0d cycles",
                 stalled_offers);
        if (tracker.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== two_class_age_ordered_fifo_core.f =====
rtl/tcaof_pkg.sv
rtl/tcaof_ram.sv
rtl/tcaof_ctrl.sv
rtl/tcaof_dp.sv
rtl/two_class_age_ordered_fifo_core.sv
bench/two_class_age_ordered_fifo_core_tb.sv
